// ===== design/tlbp_pkg.sv =====
package tlbp_pkg;

  localparam int L1_DEPTH_DEF      = 64;
  localparam int L2_PARTS_DEF      = 4;
  localparam int L2_PART_DEPTH_DEF = 256;

  localparam int VPN_LSB = 12;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  // remainder unit: divisor width covers every legal depth; reciprocal quotient
  // estimate in one step, subtract and single correction in the next
  localparam int RND_DIV_W = 11;
  localparam int RND_STEPS = 2;
  localparam int RCP_SH    = 24;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_L1   = 2'd1;
  localparam logic [1:0] HIT_L2   = 2'd2;

  typedef enum logic [2:0] {
    OP_LOOKUP   = 3'd0,
    OP_INS_L1   = 3'd1,
    OP_INS_L2   = 3'd2,
    OP_INVAL    = 3'd3,
    OP_FLUSH_L1 = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] vaddr;
    logic [15:0] pid;
    logic [4:0]  page_shift;
    logic [19:0] vpn;
    logic [19:0] pfn;
  } req_t;

  typedef struct packed {
    logic [1:0]  hit_level;
    logic [19:0] frame;
    logic [31:0] paddr;
    logic        replaced;
    logic [5:0]  replaced_index;
  } rsp_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [4:0]  shift;
    logic [19:0] vpn;
    logic [19:0] pfn;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_L1_RD, S_L1_CHK, S_L1_SH, S_L1_SHW, S_POS, S_OWN_CHK,
    S_L2_RD, S_L2_CHK, S_L2_SH, S_L2_SHW, S_EMPTY, S_PART_MOD, S_L2_PUT,
    S_SLOT_MOD, S_L1_PUT, S_L1_MOD, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    C_NOP, C_LATCH, C_FLUSH, C_L1_RD, C_L1_RD_NEXT, C_IDX_INC, C_L1_HIT,
    C_L1_SH_WR, C_L1_DEC, C_POS_INC, C_OWN_RD, C_L2_RD, C_L2_RD_NEXT,
    C_L2_HIT, C_L2_SH_WR, C_L2_DEC, C_L1_APPEND, C_L1_FIFO, C_L1_RAND,
    C_MOD_L1, C_MOD_PART, C_MOD_SLOT, C_SET_EMPTY, C_PART_FIFO, C_PART_RAND,
    C_L2_APPEND, C_L2_FIFO, C_L2_RAND, C_OUT_LOAD
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       l1_va_hit;
    logic       l1_inv_hit;
    logic       l2_va_hit;
    logic       l2_vpn_hit;
    logic       owner_hit;
    logic       l1_end;
    logic       l2_end;
    logic       l1_last;
    logic       l2_last;
    logic       pos_end;
    logic       part_empty;
    logic       l1_full;
    logic       l2_full;
    logic       empty_found;
    logic       rnd_mode;
    logic       mod_done;
    logic       out_busy;
  } dp_status_t;

  function automatic logic ent_match(entry_t e, logic [31:0] va);
    logic [31:0] m;
    m = ~((32'd1 << e.shift) - 32'd1);
    return ((va & m) >> VPN_LSB) == {12'd0, e.vpn};
  endfunction

  function automatic logic [31:0] ent_phys(entry_t e, logic [31:0] va);
    logic [31:0] m;
    m = (32'd1 << e.shift) - 32'd1;
    return ({12'd0, e.pfn} << e.shift) | (va & m);
  endfunction

  // fibonacci lfsr, taps 16 14 13 11
  function automatic logic [15:0] lfsr_step(logic [15:0] l);
    return {l[0] ^ l[2] ^ l[3] ^ l[5], l[15:1]};
  endfunction

endpackage

// ===== design/tlbp_ctrl.sv =====
module tlbp_ctrl import tlbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = C_NOP;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd        = C_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.op)
          OP_LOOKUP, OP_INVAL: state_next = S_L1_RD;
          OP_INS_L1:           state_next = S_L1_PUT;
          OP_INS_L2:           state_next = S_POS;
          OP_FLUSH_L1: begin
            cmd        = C_FLUSH;
            state_next = S_DONE;
          end
          default:             state_next = S_DONE;
        endcase
      end
      S_L1_RD: begin
        if (status.l1_end) begin
          state_next = S_POS;
        end else begin
          cmd        = C_L1_RD;
          state_next = S_L1_CHK;
        end
      end
      S_L1_CHK: begin
        if (status.op == OP_LOOKUP && status.l1_va_hit) begin
          cmd        = C_L1_HIT;
          state_next = S_DONE;
        end else if (status.op == OP_INVAL && status.l1_inv_hit) begin
          state_next = S_L1_SH;
        end else begin
          cmd        = C_IDX_INC;
          state_next = S_L1_RD;
        end
      end
      S_L1_SH: begin
        if (status.l1_last) begin
          cmd        = C_L1_DEC;
          state_next = S_POS;
        end else begin
          cmd        = C_L1_RD_NEXT;
          state_next = S_L1_SHW;
        end
      end
      S_L1_SHW: begin
        cmd        = C_L1_SH_WR;
        state_next = S_L1_SH;
      end
      S_POS: begin
        if (status.pos_end) begin
          state_next = (status.op == OP_INS_L2) ? S_EMPTY : S_DONE;
        end else if (status.part_empty) begin
          cmd = C_POS_INC;
        end else begin
          cmd        = C_OWN_RD;
          state_next = S_OWN_CHK;
        end
      end
      S_OWN_CHK: begin
        if (!status.owner_hit) begin
          cmd        = C_POS_INC;
          state_next = S_POS;
        end else if (status.op == OP_INS_L2) begin
          state_next = S_L2_PUT;
        end else begin
          state_next = S_L2_RD;
        end
      end
      S_L2_RD: begin
        if (status.l2_end) begin
          cmd        = C_POS_INC;
          state_next = S_POS;
        end else begin
          cmd        = C_L2_RD;
          state_next = S_L2_CHK;
        end
      end
      S_L2_CHK: begin
        if (status.op == OP_LOOKUP && status.l2_va_hit) begin
          cmd        = C_L2_HIT;
          state_next = S_L1_PUT;
        end else if (status.op == OP_INVAL && status.l2_vpn_hit) begin
          state_next = S_L2_SH;
        end else begin
          cmd        = C_IDX_INC;
          state_next = S_L2_RD;
        end
      end
      S_L2_SH: begin
        if (status.l2_last) begin
          cmd        = C_L2_DEC;
          state_next = S_DONE;
        end else begin
          cmd        = C_L2_RD_NEXT;
          state_next = S_L2_SHW;
        end
      end
      S_L2_SHW: begin
        cmd        = C_L2_SH_WR;
        state_next = S_L2_SH;
      end
      S_EMPTY: begin
        priority if (status.empty_found) begin
          cmd        = C_SET_EMPTY;
          state_next = S_L2_PUT;
        end else if (status.rnd_mode) begin
          cmd        = C_MOD_PART;
          state_next = S_PART_MOD;
        end else begin
          cmd        = C_PART_FIFO;
          state_next = S_L2_PUT;
        end
      end
      S_PART_MOD: begin
        if (status.mod_done) begin
          cmd        = C_PART_RAND;
          state_next = S_L2_PUT;
        end
      end
      S_L2_PUT: begin
        priority if (!status.l2_full) begin
          cmd        = C_L2_APPEND;
          state_next = S_DONE;
        end else if (status.rnd_mode) begin
          cmd        = C_MOD_SLOT;
          state_next = S_SLOT_MOD;
        end else begin
          cmd        = C_L2_FIFO;
          state_next = S_DONE;
        end
      end
      S_SLOT_MOD: begin
        if (status.mod_done) begin
          cmd        = C_L2_RAND;
          state_next = S_DONE;
        end
      end
      S_L1_PUT: begin
        priority if (!status.l1_full) begin
          cmd        = C_L1_APPEND;
          state_next = S_DONE;
        end else if (status.rnd_mode) begin
          cmd        = C_MOD_L1;
          state_next = S_L1_MOD;
        end else begin
          cmd        = C_L1_FIFO;
          state_next = S_DONE;
        end
      end
      S_L1_MOD: begin
        if (status.mod_done) begin
          cmd        = C_L1_RAND;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd        = C_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/tlbp_dp.sv =====
module tlbp_dp import tlbp_pkg::*; #(
  parameter int L1_DEPTH      = L1_DEPTH_DEF,
  parameter int L2_PARTS      = L2_PARTS_DEF,
  parameter int L2_PART_DEPTH = L2_PART_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  req_t       req,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp
);

  localparam int L1_IW = $clog2(L1_DEPTH);
  localparam int L1_CW = $clog2(L1_DEPTH + 1);
  localparam int SW    = $clog2(L2_PART_DEPTH);
  localparam int SCW   = $clog2(L2_PART_DEPTH + 1);
  localparam int PW    = (L2_PARTS > 1) ? $clog2(L2_PARTS) : 1;
  localparam int PPW   = $clog2(L2_PARTS + 1);
  localparam int AW    = $clog2(L2_PARTS * L2_PART_DEPTH);
  localparam int IXW   = (L1_CW > SCW) ? L1_CW : SCW;

  // scaled reciprocals of the three divisors
  localparam int RCP_L1   = (1 << RCP_SH) / L1_DEPTH;
  localparam int RCP_PART = (1 << RCP_SH) / L2_PARTS;
  localparam int RCP_SLOT = (1 << RCP_SH) / L2_PART_DEPTH;

  // configuration and request
  logic   policy;
  req_t   rq;
  entry_t ent;

  // level one: circular list, oldest at head
  entry_t           l1_mem [L1_DEPTH];
  entry_t           l1_rd;
  logic [L1_IW-1:0] l1_head;
  logic [L1_CW-1:0] l1_count;

  // level two: one circular list per partition
  entry_t         l2_mem [L2_PARTS * L2_PART_DEPTH];
  entry_t         l2_rd;
  logic [SW-1:0]  l2_head  [L2_PARTS];
  logic [SCW-1:0] l2_count [L2_PARTS];
  logic [PW-1:0]  l2_order [L2_PARTS];

  logic [IXW-1:0] idx;
  logic [PPW-1:0] pos;
  logic [PW-1:0]  p_sel;

  // remainder unit
  logic [15:0]            lfsr;
  logic [15:0]            mval;
  logic [15:0]            mq;
  logic [RCP_SH:0]        mrcp;
  logic [RND_DIV_W-1:0]   mdiv;
  logic [RND_DIV_W-1:0]   mrem;
  logic [4:0]             mcnt;
  logic [RCP_SH+16:0]     mprod;
  logic [15+RND_DIV_W:0]  mqd;
  logic [16:0]            mdiff;

  // result under construction
  logic [1:0]  hit;
  logic [19:0] frame;
  logic [31:0] pa;
  logic        rep;
  logic [5:0]  ridx;

  function automatic logic [L1_IW-1:0] l1_wrap(logic [L1_IW:0] s);
    return (s >= (L1_IW+1)'(L1_DEPTH)) ? L1_IW'(s - (L1_IW+1)'(L1_DEPTH)) : L1_IW'(s);
  endfunction

  function automatic logic [AW-1:0] l2_addr(logic [PW-1:0] p, logic [SW:0] s);
    logic [SW-1:0] w;
    w = (s >= (SW+1)'(L2_PART_DEPTH)) ? SW'(s - (SW+1)'(L2_PART_DEPTH)) : SW'(s);
    return AW'(p * L2_PART_DEPTH) + AW'(w);
  endfunction

  logic [PW-1:0]  cur_p;
  logic [PW-1:0]  emp_p;
  logic           emp_found;
  logic [SW-1:0]  sel_head;
  logic [SCW-1:0] sel_count;
  logic [IXW-1:0] idx_inc;

  assign cur_p     = l2_order[pos[PW-1:0]];
  assign sel_head  = l2_head[p_sel];
  assign sel_count = l2_count[p_sel];
  assign idx_inc   = idx + IXW'(1);

  always_comb begin
    emp_found = 1'b0;
    emp_p     = '0;
    for (int i = L2_PARTS - 1; i >= 0; i--) begin
      if (l2_count[l2_order[i]] == '0) begin
        emp_found = 1'b1;
        emp_p     = l2_order[i];
      end
    end
  end

  // memory ports
  logic             l1_we;
  logic [L1_IW-1:0] l1_wa, l1_ra;
  entry_t           l1_wd;
  logic             l2_we;
  logic [AW-1:0]    l2_wa, l2_ra;
  entry_t           l2_wd;

  always_comb begin
    l1_we = 1'b0;
    l1_wa = l1_wrap((L1_IW+1)'(l1_head) + (L1_IW+1)'(l1_count));
    l1_wd = ent;
    l1_ra = l1_wrap((L1_IW+1)'(l1_head) + (L1_IW+1)'(idx));
    l2_we = 1'b0;
    l2_wa = l2_addr(p_sel, (SW+1)'(sel_head) + (SW+1)'(sel_count));
    l2_wd = ent;
    l2_ra = l2_addr(p_sel, (SW+1)'(sel_head) + (SW+1)'(idx));
    unique case (cmd)
      C_L1_RD_NEXT: l1_ra = l1_wrap((L1_IW+1)'(l1_head) + (L1_IW+1)'(idx_inc));
      C_L1_APPEND:  l1_we = 1'b1;
      C_L1_FIFO: begin
        l1_we = 1'b1;
        l1_wa = l1_head;
      end
      C_L1_RAND: begin
        l1_we = 1'b1;
        l1_wa = l1_wrap((L1_IW+1)'(l1_head) + (L1_IW+1)'(mrem));
      end
      C_L1_SH_WR: begin
        l1_we = 1'b1;
        l1_wa = l1_ra;
        l1_wd = l1_rd;
      end
      C_OWN_RD: l2_ra = l2_addr(cur_p, (SW+1)'(l2_head[cur_p])
                                + (SW+1)'(l2_count[cur_p] - SCW'(1)));
      C_L2_RD_NEXT: l2_ra = l2_addr(p_sel, (SW+1)'(sel_head) + (SW+1)'(idx_inc));
      C_L2_APPEND: l2_we = 1'b1;
      C_L2_FIFO: begin
        l2_we = 1'b1;
        l2_wa = l2_addr(p_sel, (SW+1)'(sel_head));
      end
      C_L2_RAND: begin
        l2_we = 1'b1;
        l2_wa = l2_addr(p_sel, (SW+1)'(sel_head) + (SW+1)'(mrem));
      end
      C_L2_SH_WR: begin
        l2_we = 1'b1;
        l2_wa = l2_ra;
        l2_wd = l2_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[l1_wa] <= l1_wd;
    l1_rd <= l1_mem[l1_ra];
  end

  always_ff @(posedge clk) begin
    if (l2_we) l2_mem[l2_wa] <= l2_wd;
    l2_rd <= l2_mem[l2_ra];
  end

  // quotient estimate is at most one short, so one subtract corrects it
  assign mprod = (RCP_SH+17)'(mval) * (RCP_SH+17)'(mrcp);
  assign mqd   = (16+RND_DIV_W)'(mq) * (16+RND_DIV_W)'(mdiv);
  assign mdiff = 17'(mval) - mqd[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= 1'b0;
      l1_head   <= '0;
      l1_count  <= '0;
      lfsr      <= LFSR_SEED;
      mcnt      <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < L2_PARTS; i++) begin
        l2_head[i]  <= '0;
        l2_count[i] <= '0;
        l2_order[i] <= PW'(i);
      end
    end else begin
      if (cfg_we) policy <= cfg_wdata;
      rsp_valid <= (cmd == C_OUT_LOAD) || (rsp_valid && rsp_stall);
      if (mcnt == 5'(RND_STEPS)) mq <= mprod[RCP_SH+15:RCP_SH];
      if (mcnt == 5'd1) begin
        mrem <= (mdiff >= 17'(mdiv)) ? RND_DIV_W'(mdiff - 17'(mdiv)) : RND_DIV_W'(mdiff);
      end
      if (mcnt != '0) mcnt <= mcnt - 5'd1;
      unique case (cmd)
        C_LATCH: begin
          rq    <= req;
          ent   <= '{pid: req.pid, shift: req.page_shift, vpn: req.vpn,
                     pfn: req.pfn};
          idx   <= '0;
          pos   <= '0;
          hit   <= HIT_NONE;
          frame <= '0;
          pa    <= '0;
          rep   <= 1'b0;
          ridx  <= '0;
        end
        C_FLUSH:    l1_count <= '0;
        C_IDX_INC:  idx <= idx_inc;
        C_L1_HIT: begin
          hit   <= HIT_L1;
          frame <= l1_rd.pfn;
          pa    <= ent_phys(l1_rd, rq.vaddr);
        end
        C_L1_SH_WR: idx <= idx_inc;
        C_L1_DEC:   l1_count <= l1_count - L1_CW'(1);
        C_POS_INC:  pos <= pos + PPW'(1);
        C_OWN_RD: begin
          p_sel <= cur_p;
          idx   <= '0;
        end
        C_L2_HIT: begin
          hit   <= HIT_L2;
          frame <= l2_rd.pfn;
          pa    <= ent_phys(l2_rd, rq.vaddr);
          ent   <= l2_rd;
        end
        C_L2_SH_WR: idx <= idx_inc;
        C_L2_DEC:   l2_count[p_sel] <= sel_count - SCW'(1);
        C_L1_APPEND: l1_count <= l1_count + L1_CW'(1);
        C_L1_FIFO: begin
          l1_head <= l1_wrap((L1_IW+1)'(l1_head) + (L1_IW+1)'(1));
          rep     <= 1'b1;
        end
        C_L1_RAND: begin
          rep  <= 1'b1;
          ridx <= 6'(mrem);
        end
        C_MOD_L1, C_MOD_PART, C_MOD_SLOT: begin
          lfsr <= lfsr_step(lfsr);
          mval <= lfsr_step(lfsr);
          mcnt <= 5'(RND_STEPS);
          mdiv <= (cmd == C_MOD_L1)   ? RND_DIV_W'(L1_DEPTH) :
                  (cmd == C_MOD_PART) ? RND_DIV_W'(L2_PARTS) : RND_DIV_W'(L2_PART_DEPTH);
          mrcp <= (cmd == C_MOD_L1)   ? (RCP_SH+1)'(RCP_L1) :
                  (cmd == C_MOD_PART) ? (RCP_SH+1)'(RCP_PART) : (RCP_SH+1)'(RCP_SLOT);
        end
        C_SET_EMPTY: p_sel <= emp_p;
        C_PART_FIFO: begin
          p_sel <= l2_order[0];
          l2_count[l2_order[0]] <= '0;
          for (int i = 0; i + 1 < L2_PARTS; i++) l2_order[i] <= l2_order[i+1];
          l2_order[L2_PARTS-1] <= l2_order[0];
        end
        C_PART_RAND: begin
          p_sel <= PW'(mrem);
          l2_count[PW'(mrem)] <= '0;
        end
        C_L2_APPEND: l2_count[p_sel] <= sel_count + SCW'(1);
        C_L2_FIFO: l2_head[p_sel] <= SW'(l2_addr('0, (SW+1)'(sel_head) + (SW+1)'(1)));
        C_OUT_LOAD: begin
          rsp <= '{hit_level: hit, frame: frame, paddr: pa, replaced: rep,
                   replaced_index: ridx};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.op          = rq.op;
    status.l1_va_hit   = ent_match(l1_rd, rq.vaddr);
    status.l1_inv_hit  = (l1_rd.pid == rq.pid) && (l1_rd.vpn == rq.vpn);
    status.l2_va_hit   = ent_match(l2_rd, rq.vaddr);
    status.l2_vpn_hit  = (l2_rd.vpn == rq.vpn);
    status.owner_hit   = (l2_rd.pid == rq.pid);
    status.l1_end      = (idx == IXW'(l1_count));
    status.l2_end      = (idx == IXW'(sel_count));
    status.l1_last     = (idx_inc == IXW'(l1_count));
    status.l2_last     = (idx_inc == IXW'(sel_count));
    status.pos_end     = (pos == PPW'(L2_PARTS));
    status.part_empty  = (l2_count[cur_p] == '0);
    status.l1_full     = (l1_count == L1_CW'(L1_DEPTH));
    status.l2_full     = (sel_count == SCW'(L2_PART_DEPTH));
    status.empty_found = emp_found;
    status.rnd_mode    = policy;
    status.mod_done    = (mcnt == '0);
    status.out_busy    = rsp_valid && rsp_stall;
  end

  a_l1_bound: assert property (@(posedge clk) disable iff (rst)
    l1_count <= L1_CW'(L1_DEPTH)) else $error("l1 count beyond depth");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd == C_OUT_LOAD |-> !(rsp_valid && rsp_stall)) else $error("result overwritten");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd == C_OUT_LOAD |=> rsp_valid) else $error("result not presented");
  a_mod_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd == C_MOD_L1 || cmd == C_MOD_PART || cmd == C_MOD_SLOT) |-> mcnt == '0)
    else $error("remainder unit restarted while busy");

endmodule

// ===== design/two_level_tlb_partitioned.sv =====
// channel   direction  handshake               beat
// req       in         req_valid / req_stall   req_t: op, address, process, page, frame
// rsp       out        rsp_valid / rsp_stall   rsp_t: hit level, frame, address, replacement
// cfg       in         cfg_we                  replace policy bit
//
// one request at a time; a lookup walks the l1 list then the owning l2 partitions,
// reading one entry at a time through the memory port; removals shift the tail down one
// entry at a time; each random choice waits on the lfsr remainder unit
// synchronous reset clears counts and list heads, restores partition order and loads the lfsr seed; no sweep
// a waiting result sits in the output register while the next request is taken
module two_level_tlb_partitioned import tlbp_pkg::*; #(
  parameter int L1_DEPTH      = L1_DEPTH_DEF,
  parameter int L2_PARTS      = L2_PARTS_DEF,
  parameter int L2_PART_DEPTH = L2_PART_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: walks lists and partitions one memory access at a time
  tlbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, counts, lfsr remainder unit and output register
  tlbp_dp #(
    .L1_DEPTH      (L1_DEPTH),
    .L2_PARTS      (L2_PARTS),
    .L2_PART_DEPTH (L2_PART_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
